[rtl/m3inv_pkg.sv]
// ----------------------------------------------------------------------------
// m3inv_pkg
// Shared types, constants and helpers of the 3x3 matrix inverse core.
// ----------------------------------------------------------------------------
package m3inv_pkg;

	localparam int NE    = 9;
	localparam int DW    = 32;
	localparam int PW    = 64;
	localparam int ADJW  = 65;
	localparam int MAGW  = 64;
	localparam int TW    = 96;
	localparam int DETW  = 97;
	localparam int DMW   = 96;
	localparam int QW    = 33;
	localparam int NSTEP = 33;
	localparam int CW    = DMW + QW;
	localparam int SATW  = 65;
	localparam int MIDD  = 4;
	localparam int MAW   = $clog2(MIDD);
	localparam int MCW   = $clog2(MIDD + 1);
	localparam int OUTD  = 2;
	localparam int OAW   = $clog2(OUTD);
	localparam int OCW   = $clog2(OUTD + 1);

	// Cofactor operand pairs: adj[k] = a[PA]*a[PB] - a[QA]*a[QB].
	localparam int PA [NE] = '{4, 7, 1, 6, 0, 2, 3, 1, 0};
	localparam int PB [NE] = '{8, 2, 5, 5, 8, 3, 7, 6, 4};
	localparam int QA [NE] = '{5, 1, 2, 3, 6, 0, 6, 0, 1};
	localparam int QB [NE] = '{7, 8, 4, 8, 2, 5, 4, 7, 3};
	localparam int TSRC [NE] = '{0, 3, 6, 1, 4, 7, 2, 5, 8};
	localparam int TERM_EL [3] = '{0, 3, 6};

	typedef logic [NE-1:0][DW-1:0] mat_t;

	typedef struct packed {
		logic                     sing;
		logic                     det_neg;
		logic [DMW-1:0]           dmag;
		logic [DW-1:0]            detv;
		logic [NE-1:0]            adj_neg;
		logic [NE-1:0][MAGW-1:0]  adj_mag;
		mat_t                     a;
	} mid_t;

	typedef struct packed {
		mat_t           r;
		logic           sing;
		logic [DW-1:0]  detv;
	} res_t;

	// Signed magnitude to a saturated 32-bit two's complement value.
	function automatic logic [DW-1:0] sat32(input logic neg, input logic [SATW-1:0] mag);
		logic [DW-1:0] v;
		if (neg) begin
			if (mag > SATW'(64'h8000_0000)) v = 32'h8000_0000;
			else v = ~mag[DW-1:0] + 32'd1;
		end else begin
			if (mag > SATW'(64'h7FFF_FFFF)) v = 32'h7FFF_FFFF;
			else v = mag[DW-1:0];
		end
		return v;
	endfunction

endpackage

[rtl/m3inv_front.sv]
// ----------------------------------------------------------------------------
// m3inv_front
// Accepts matrices, forms the adjugate and the determinant, and classifies
// each matrix as singular or invertible.
// ----------------------------------------------------------------------------
module m3inv_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  m3inv_pkg::mat_t   a_in,
	output logic              mid_push,
	output m3inv_pkg::mid_t   mid_data,
	input  logic              mid_full
);
	import m3inv_pkg::*;

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;

	mat_t a_s1, a_s2, a_s3, a_s4, a_s5;
	logic signed [PW-1:0] pp_s1 [NE];
	logic signed [PW-1:0] pq_s1 [NE];
	logic signed [PW-1:0] pp_d [NE];
	logic signed [PW-1:0] pq_d [NE];
	logic [ADJW-1:0] adj_s2 [NE];
	logic [ADJW-1:0] adj_d [NE];
	logic [ADJW-1:0] adjn_d [NE];
	logic [NE-1:0] adj_neg_d, adj_neg_s3, adj_neg_s4, adj_neg_s5;
	logic [NE-1:0][MAGW-1:0] adj_mag_d, adj_mag_s3, adj_mag_s4, adj_mag_s5;
	logic [DW-1:0] am_d [3];
	logic [PW-1:0] plo_d [3];
	logic [PW-1:0] phi_d [3];
	logic [PW-1:0] plo_s3 [3];
	logic [PW-1:0] phi_s3 [3];
	logic [2:0] tneg_d, tneg_s3;
	logic [TW-1:0] t_d [3];
	logic [DETW-1:0] ts_d [3];
	logic [DETW-1:0] ts_s4 [3];
	logic [DETW-1:0] det_d, det_s5, det_abs;
	logic [SATW-1:0] dq;
	mid_t mid_d, mid_s6;

	assign en       = !v_s6 || !mid_full;
	assign full     = !en;
	assign mid_push = v_s6 && !mid_full;
	assign mid_data = mid_s6;

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			pp_d[k] = $signed(a_in[PA[k]]) * $signed(a_in[PB[k]]);
			pq_d[k] = $signed(a_in[QA[k]]) * $signed(a_in[QB[k]]);
			adj_d[k] = {pp_s1[k][PW-1], pp_s1[k]} - {pq_s1[k][PW-1], pq_s1[k]};
			adjn_d[k] = -adj_s2[k];
			adj_neg_d[k] = adj_s2[k][ADJW-1];
			adj_mag_d[k] = adj_neg_d[k] ? adjn_d[k][MAGW-1:0] : adj_s2[k][MAGW-1:0];
		end
		for (int j = 0; j < 3; j++) begin
			am_d[j] = a_s2[TERM_EL[j]][DW-1] ? -a_s2[TERM_EL[j]] : a_s2[TERM_EL[j]];
			plo_d[j] = am_d[j] * adj_mag_d[j][DW-1:0];
			phi_d[j] = am_d[j] * adj_mag_d[j][MAGW-1:DW];
			tneg_d[j] = a_s2[TERM_EL[j]][DW-1] ^ adj_neg_d[j];
			t_d[j] = {{DW{1'b0}}, plo_s3[j]} + {phi_s3[j], {DW{1'b0}}};
			ts_d[j] = tneg_s3[j] ? -{1'b0, t_d[j]} : {1'b0, t_d[j]};
		end
		det_d   = ts_s4[0] + ts_s4[1] + ts_s4[2];
		det_abs = det_s5[DETW-1] ? -det_s5 : det_s5;
		dq      = {1'b0, det_abs[DMW-1:DW]} + SATW'(det_abs[DW-1]);
		mid_d.sing    = (det_s5 == '0);
		mid_d.det_neg = det_s5[DETW-1];
		mid_d.dmag    = det_abs[DMW-1:0];
		mid_d.detv    = sat32(det_s5[DETW-1], dq);
		mid_d.adj_neg = adj_neg_s5;
		mid_d.adj_mag = adj_mag_s5;
		mid_d.a       = a_s5;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_s1       <= a_in;
			pp_s1      <= pp_d;
			pq_s1      <= pq_d;
			a_s2       <= a_s1;
			adj_s2     <= adj_d;
			a_s3       <= a_s2;
			adj_neg_s3 <= adj_neg_d;
			adj_mag_s3 <= adj_mag_d;
			plo_s3     <= plo_d;
			phi_s3     <= phi_d;
			tneg_s3    <= tneg_d;
			a_s4       <= a_s3;
			adj_neg_s4 <= adj_neg_s3;
			adj_mag_s4 <= adj_mag_s3;
			ts_s4      <= ts_d;
			a_s5       <= a_s4;
			adj_neg_s5 <= adj_neg_s4;
			adj_mag_s5 <= adj_mag_s4;
			det_s5     <= det_d;
			mid_s6     <= mid_d;
		end
	end

`ifndef SYNTHESIS
	a_accept_enters: assert property (@(posedge clk) disable iff (!arst_n)
		push && !full |=> v_s1) else $error("accepted matrix did not enter the front pipeline");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && mid_full |=> v_s6 && $stable(mid_s6)) else $error("stalled front output changed");
	a_sing_det: assert property (@(posedge clk) disable iff (!arst_n)
		v_s6 && mid_s6.sing |-> mid_s6.detv == '0) else $error("singular matrix with nonzero det");
`endif

endmodule

[rtl/m3inv_fifo.sv]
// ----------------------------------------------------------------------------
// m3inv_fifo
// Short queue that decouples the classifying front from the divider back.
// ----------------------------------------------------------------------------
module m3inv_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             wr_en,
	input  m3inv_pkg::mid_t  wr_data,
	output logic             full,
	input  logic             rd_en,
	output m3inv_pkg::mid_t  rd_data,
	output logic             empty
);
	import m3inv_pkg::*;

	mid_t mem_q [MIDD];
	logic [MAW-1:0] wptr_q, rptr_q;
	logic [MCW-1:0] cnt_q;

	assign full    = (cnt_q == MCW'(MIDD));
	assign empty   = (cnt_q == '0);
	assign rd_data = mem_q[rptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr_en) wptr_q <= wptr_q + 1'b1;
			if (rd_en) rptr_q <= rptr_q + 1'b1;
			if (wr_en && !rd_en) cnt_q <= cnt_q + 1'b1;
			else if (!wr_en && rd_en) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem_q[wptr_q] <= wr_data;
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !full) else $error("write into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !empty) else $error("read from empty queue");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= MCW'(MIDD)) else $error("queue count out of range");
`endif

endmodule

[rtl/m3inv_back.sv]
// ----------------------------------------------------------------------------
// m3inv_back
// Divides each adjugate entry by the determinant in a pipelined restoring
// divider, rounds and saturates, and holds results in a small output queue.
// ----------------------------------------------------------------------------
module m3inv_back (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             transpose,
	input  m3inv_pkg::mid_t  mid_data,
	input  logic             mid_empty,
	output logic             mid_pop,
	output logic             empty,
	input  logic             pop,
	output m3inv_pkg::res_t  res
);
	import m3inv_pkg::*;

	logic en;
	logic [NSTEP:0] v_q;
	logic [DMW-1:0] rem_q [NSTEP+1][NE];
	logic [QW-1:0]  quo_q [NSTEP+1][NE];
	logic [NE-1:0]  neg_q [NSTEP+1];
	logic [NE-1:0]  ovf_q [NSTEP+1];
	logic           sing_q [NSTEP+1];
	logic [DMW-1:0] dmag_q [NSTEP+1];
	logic [DW-1:0]  detv_q [NSTEP+1];
	logic [DMW-1:0] rem_d [NSTEP+1][NE];
	logic [QW-1:0]  quo_d [NSTEP+1][NE];
	logic [NE-1:0]  ovf_d;
	logic [NE-1:0]  neg_d;
	logic [CW-1:0]  dsh, rext, diff;
	logic [MAGW-1:0] cm;
	logic           rnd;
	logic [QW:0]    qr;
	logic [SATW-1:0] mag;
	res_t           res_d;
	res_t           out_mem_q [OUTD];
	logic [OAW-1:0] out_wptr_q, out_rptr_q;
	logic [OCW-1:0] out_cnt_q;
	logic           out_push, out_pop;

	assign en       = !v_q[NSTEP] || (out_cnt_q < OCW'(OUTD));
	assign mid_pop  = en && !mid_empty;
	assign out_push = v_q[NSTEP] && en;
	assign out_pop  = pop && !empty;
	assign empty    = (out_cnt_q == '0);
	assign res      = out_mem_q[out_rptr_q];

	always_comb begin
		for (int k = 0; k < NE; k++) begin
			cm = transpose ? mid_data.adj_mag[TSRC[k]] : mid_data.adj_mag[k];
			neg_d[k] = (transpose ? mid_data.adj_neg[TSRC[k]] : mid_data.adj_neg[k])
				^ mid_data.det_neg;
			rem_d[0][k] = {cm, {DW{1'b0}}};
			ovf_d[k] = {{QW{1'b0}}, cm, {DW{1'b0}}} >= {mid_data.dmag, {QW{1'b0}}};
			quo_d[0][k] = mid_data.sing ? {1'b0, mid_data.a[k]} : '0;
		end
		for (int j = 1; j <= NSTEP; j++) begin
			for (int k = 0; k < NE; k++) begin
				dsh  = {{QW{1'b0}}, dmag_q[j-1]} << (NSTEP - j);
				rext = {{QW{1'b0}}, rem_q[j-1][k]};
				diff = rext - dsh;
				rem_d[j][k] = rem_q[j-1][k];
				quo_d[j][k] = quo_q[j-1][k];
				if (!sing_q[j-1] && rext >= dsh) begin
					rem_d[j][k] = diff[DMW-1:0];
					quo_d[j][k][NSTEP-j] = 1'b1;
				end
			end
		end
		res_d.sing = sing_q[NSTEP];
		res_d.detv = detv_q[NSTEP];
		for (int k = 0; k < NE; k++) begin
			rnd = {rem_q[NSTEP][k], 1'b0} >= {1'b0, dmag_q[NSTEP]};
			qr  = {1'b0, quo_q[NSTEP][k]} + (QW+1)'(rnd);
			mag = ovf_q[NSTEP][k] ? '1 : SATW'(qr);
			res_d.r[k] = sing_q[NSTEP] ? quo_q[NSTEP][k][DW-1:0]
				: sat32(neg_q[NSTEP][k], mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q        <= '0;
			out_wptr_q <= '0;
			out_rptr_q <= '0;
			out_cnt_q  <= '0;
		end else begin
			if (en) v_q <= {v_q[NSTEP-1:0], !mid_empty};
			if (out_push) out_wptr_q <= out_wptr_q + 1'b1;
			if (out_pop) out_rptr_q <= out_rptr_q + 1'b1;
			if (out_push && !out_pop) out_cnt_q <= out_cnt_q + 1'b1;
			else if (!out_push && out_pop) out_cnt_q <= out_cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0]  <= rem_d[0];
			quo_q[0]  <= quo_d[0];
			neg_q[0]  <= neg_d;
			ovf_q[0]  <= ovf_d;
			sing_q[0] <= mid_data.sing;
			dmag_q[0] <= mid_data.dmag;
			detv_q[0] <= mid_data.detv;
			for (int j = 1; j <= NSTEP; j++) begin
				rem_q[j]  <= rem_d[j];
				quo_q[j]  <= quo_d[j];
				neg_q[j]  <= neg_q[j-1];
				ovf_q[j]  <= ovf_q[j-1];
				sing_q[j] <= sing_q[j-1];
				dmag_q[j] <= dmag_q[j-1];
				detv_q[j] <= detv_q[j-1];
			end
		end
		if (out_push) out_mem_q[out_wptr_q] <= res_d;
	end

`ifndef SYNTHESIS
	a_out_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_cnt_q <= OCW'(OUTD)) else $error("output queue count out of range");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty) else $error("back took a request from an empty queue");
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		v_q[NSTEP] && !en |=> v_q[NSTEP]) else $error("stalled result was dropped");
`endif

endmodule

[rtl/matrix3_inverse_with_singular_flag_core.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_with_singular_flag_core
// 3x3 Q16.16 matrix inverse by adjugate with singular flag and saturation.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake         Payload
// input     in         push / full       a0..a8
// result    out        empty / pop       r0..r8, singular, det_value
// config    in         cfg_valid/ready   cfg_data (transpose_result)
//
// One matrix is accepted per cycle when nothing downstream stalls.
// A result reaches the ports through 6 front stages for products, adjugate
// and determinant, the decoupling queue, 34 divider stages that settle one
// quotient bit each after the first, and the output queue. Front and back
// stall independently; full rises only when the front's last stage cannot
// enter the queue.
// Reset clears all control state.
// ----------------------------------------------------------------------------
module matrix3_inverse_with_singular_flag_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [31:0] a0,
	input  logic signed [31:0] a1,
	input  logic signed [31:0] a2,
	input  logic signed [31:0] a3,
	input  logic signed [31:0] a4,
	input  logic signed [31:0] a5,
	input  logic signed [31:0] a6,
	input  logic signed [31:0] a7,
	input  logic signed [31:0] a8,
	output logic               empty,
	input  logic               pop,
	output logic signed [31:0] r0,
	output logic signed [31:0] r1,
	output logic signed [31:0] r2,
	output logic signed [31:0] r3,
	output logic signed [31:0] r4,
	output logic signed [31:0] r5,
	output logic signed [31:0] r6,
	output logic signed [31:0] r7,
	output logic signed [31:0] r8,
	output logic               singular,
	output logic signed [31:0] det_value,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_data
);
	import m3inv_pkg::*;

	logic transpose_q;
	mat_t a_in;
	mid_t mid_wdata, mid_rdata;
	logic mid_push, mid_full, mid_pop, mid_empty;
	res_t res;

	assign cfg_ready = 1'b1;
	assign a_in = {a8, a7, a6, a5, a4, a3, a2, a1, a0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			transpose_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			transpose_q <= cfg_data;
		end
	end

	m3inv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.a_in     (a_in),
		.mid_push (mid_push),
		.mid_data (mid_wdata),
		.mid_full (mid_full)
	);

	m3inv_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (mid_push),
		.wr_data (mid_wdata),
		.full    (mid_full),
		.rd_en   (mid_pop),
		.rd_data (mid_rdata),
		.empty   (mid_empty)
	);

	m3inv_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.transpose (transpose_q),
		.mid_data  (mid_rdata),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.empty     (empty),
		.pop       (pop),
		.res       (res)
	);

	assign r0        = res.r[0];
	assign r1        = res.r[1];
	assign r2        = res.r[2];
	assign r3        = res.r[3];
	assign r4        = res.r[4];
	assign r5        = res.r[5];
	assign r6        = res.r[6];
	assign r7        = res.r[7];
	assign r8        = res.r[8];
	assign singular  = res.sing;
	assign det_value = res.detv;

endmodule
